// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the requantizer RTL; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The condition must hold at every clock edge outside reset.
`define MXRQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mxrq assertion failed");
// When the antecedent holds, the consequent must hold in the same cycle.
`define MXRQ_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mxrq assertion failed");
// When the antecedent holds, the consequent must hold in the next cycle.
`define MXRQ_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mxrq assertion failed");
`else
`define MXRQ_ASSERT(lbl, prop)
`define MXRQ_IMPLY(lbl, ante, cons)
`define MXRQ_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/mxrq_pkg.sv =====
// Shared constants, types and the FP4 to E4M3 conversion of the requantizer.
package mxrq_pkg;

    localparam int BLOCK_ROWS    = 32;
    localparam int BYTES_PER_ROW = 16;
    localparam int PAIR_W        = 4;
    localparam int ROW_W         = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [PAIR_W-1:0] pair_t;

    localparam row_t  LAST_ROW  = row_t'(BLOCK_ROWS - 1);
    localparam pair_t LAST_PAIR = pair_t'(BYTES_PER_ROW - 1);

    localparam logic [7:0] NAN_SCALE  = 8'd255;
    localparam logic [7:0] SCALE_BIAS = 8'd6;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_NAN   = 2'd1,
        STATUS_SMALL = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  take;        // input transfer this cycle
        logic  advance;     // stage A moves into the output register
        logic  scale_phase; // the transferred byte is a row scale
        logic  last_scale;  // the transferred byte is the final row scale
        logic  last_pair;   // the transferred byte is the final pair byte
        row_t  scale_addr;  // store address of the row scale
        row_t  row;         // row of the pair byte
        pair_t pair;        // byte position within the row
    } cmd_t;

    // Converts one E2M1 nibble, scaled by 2^(6 - d), into an E4M3 code with
    // round-to-nearest-even. d is the maximum scale minus the row scale.
    function automatic logic [7:0] fp4_to_e4m3(input logic [3:0] nib, input logic [7:0] d);
        logic [2:0]        mag;
        logic [3:0]        epb;
        logic              f;
        logic signed [9:0] t;
        logic [7:0]        code;
        mag = nib[2:0];
        // epb is the FP4 exponent plus 13; f is its mantissa bit.
        case (mag)
            3'd1:    begin epb = 4'd12; f = 1'b0;   end
            3'd2,
            3'd3:    begin epb = 4'd13; f = mag[0]; end
            3'd4,
            3'd5:    begin epb = 4'd14; f = mag[0]; end
            3'd6,
            3'd7:    begin epb = 4'd15; f = mag[0]; end
            default: begin epb = 4'd0;  f = 1'b0;   end
        endcase
        // t is the biased E4M3 exponent field before range limiting.
        t = $signed({6'd0, epb}) - $signed({2'd0, d});
        if (mag == 3'd0) begin
            code = 8'd0;
        end
        else if (t >= 10'sd1) begin
            code = {1'b0, t[3:0], f, 2'b00};
        end
        else if (t == 10'sd0) begin
            code = {5'd0, 1'b1, f, 1'b0};
        end
        else if (t == -10'sd1) begin
            code = {6'd0, 1'b1, f};
        end
        else if (t == -10'sd2) begin
            // 1.0 or 1.5 times the lowest subnormal step: ties go to even.
            code = f ? 8'd2 : 8'd1;
        end
        else if (t == -10'sd3) begin
            code = f ? 8'd1 : 8'd0;
        end
        else begin
            code = 8'd0;
        end
        if (nib[3] && (mag != 3'd0)) begin
            code[7] = 1'b1;
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/mxfp4_block_to_fp8_requantizer.sv =====
// A result passes through stage A and the output register after the transfer of its byte.
// Throughput: one byte per cycle while byte_stall is low; the registered read of the
// row scale store sets the depth.
// A block of 32 scale bytes and 512 pair bytes gives 513 results in 544 transfers.
// Reset clears the block phase, counters, maximum, status and pipeline valid flags.
// The row scale store is not cleared; every entry is written before it is read.
module mxfp4_block_to_fp8_requantizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       is_header,
    output logic [7:0] shared_scale,
    output logic [1:0] status,
    output logic [7:0] weight_even,
    output logic [7:0] weight_odd,
    output logic [4:0] row_index,
    output logic [3:0] pair_index,
    output logic       last
);

    mxrq_pkg::cmd_t cmd;

    mxrq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    mxrq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .is_header    (is_header),
        .shared_scale (shared_scale),
        .status       (status),
        .weight_even  (weight_even),
        .weight_odd   (weight_odd),
        .row_index    (row_index),
        .pair_index   (pair_index),
        .last         (last)
    );

endmodule

// ===== rtl/core/mxrq_ctrl.sv =====
// Controller of the requantizer: block phase, byte counters and pipeline handshake.
`include "assert_macros.svh"
module mxrq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    output logic            result_valid,
    input  logic            result_stall,
    output mxrq_pkg::cmd_t  cmd
);

    typedef enum logic {
        ST_SCALES,
        ST_PAIRS
    } state_t;

    state_t                state_reg, state_next;
    mxrq_pkg::row_t        scale_cnt_reg, scale_cnt_next;
    mxrq_pkg::row_t        row_cnt_reg, row_cnt_next;
    mxrq_pkg::pair_t       pair_cnt_reg, pair_cnt_next;
    logic                  a_valid_reg, a_valid_next;
    logic                  o_valid_reg, o_valid_next;

    logic o_free;
    logic advance;
    logic take;
    logic last_scale;
    logic last_pair;

    always_comb
    begin
        o_free     = !o_valid_reg || !result_stall;
        advance    = a_valid_reg && o_free;
        take       = byte_valid && (!a_valid_reg || advance);
        last_scale = (state_reg == ST_SCALES) && (scale_cnt_reg == mxrq_pkg::LAST_ROW);
        last_pair  = (state_reg == ST_PAIRS) && (row_cnt_reg == mxrq_pkg::LAST_ROW)
                     && (pair_cnt_reg == mxrq_pkg::LAST_PAIR);

        state_next     = state_reg;
        scale_cnt_next = scale_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        pair_cnt_next  = pair_cnt_reg;

        if (take) begin
            case (state_reg)
                ST_SCALES:
                begin
                    if (last_scale) begin
                        scale_cnt_next = '0;
                        state_next     = ST_PAIRS;
                    end
                    else begin
                        scale_cnt_next = scale_cnt_reg + 1'b1;
                    end
                end
                ST_PAIRS:
                begin
                    pair_cnt_next = pair_cnt_reg + 1'b1;
                    if (last_pair) begin
                        row_cnt_next = '0;
                        state_next   = ST_SCALES;
                    end
                    else if (pair_cnt_reg == mxrq_pkg::LAST_PAIR) begin
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_next = ST_SCALES;
                end
            endcase
        end

        // Scale bytes other than the last one leave no result behind.
        if (take && ((state_reg == ST_PAIRS) || last_scale)) begin
            a_valid_next = 1'b1;
        end
        else if (advance) begin
            a_valid_next = 1'b0;
        end
        else begin
            a_valid_next = a_valid_reg;
        end

        if (advance) begin
            o_valid_next = 1'b1;
        end
        else if (o_free) begin
            o_valid_next = 1'b0;
        end
        else begin
            o_valid_next = o_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_SCALES;
            scale_cnt_reg <= '0;
            row_cnt_reg   <= '0;
            pair_cnt_reg  <= '0;
            a_valid_reg   <= 1'b0;
            o_valid_reg   <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            scale_cnt_reg <= scale_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            pair_cnt_reg  <= pair_cnt_next;
            a_valid_reg   <= a_valid_next;
            o_valid_reg   <= o_valid_next;
        end
    end

    assign byte_stall   = a_valid_reg && !o_free;
    assign result_valid = o_valid_reg;

    always_comb
    begin
        cmd.take        = take;
        cmd.advance     = advance;
        cmd.scale_phase = (state_reg == ST_SCALES);
        cmd.last_scale  = last_scale;
        cmd.last_pair   = last_pair;
        cmd.scale_addr  = scale_cnt_reg;
        cmd.row         = row_cnt_reg;
        cmd.pair        = pair_cnt_reg;
    end

    `MXRQ_IMPLY(a_pairs_scale_cnt_clear, state_reg == ST_PAIRS, scale_cnt_reg == '0)
    `MXRQ_NEXT(a_last_scale_enters_pairs, take && last_scale,
        state_reg == ST_PAIRS && row_cnt_reg == '0 && pair_cnt_reg == '0)
    `MXRQ_NEXT(a_last_pair_ends_block, take && last_pair,
        state_reg == ST_SCALES && a_valid_reg)

endmodule

// ===== rtl/core/mxrq_datapath.sv =====
// Datapath of the requantizer: scale store, block maximum and status, conversion stages.
`include "assert_macros.svh"
module mxrq_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mxrq_pkg::cmd_t        cmd,
    input  logic [7:0]            data_byte,
    output logic                  is_header,
    output logic [7:0]            shared_scale,
    output logic [1:0]            status,
    output logic [7:0]            weight_even,
    output logic [7:0]            weight_odd,
    output logic [4:0]            row_index,
    output logic [3:0]            pair_index,
    output logic                  last
);

    logic [7:0]        scale_mem [mxrq_pkg::BLOCK_ROWS];
    logic [7:0]        scale_q_reg;

    logic [7:0]        max_reg, max_next;
    mxrq_pkg::status_t err_reg, err_next;

    // Stage A holds one transferred byte while its row scale is read.
    logic [7:0]        a_byte_reg;
    logic              a_hdr_reg;
    logic [7:0]        a_max_reg;
    mxrq_pkg::status_t a_err_reg;
    mxrq_pkg::row_t    a_row_reg;
    mxrq_pkg::pair_t   a_pair_reg;
    logic              a_last_reg;

    logic [7:0]        max_upd;
    mxrq_pkg::status_t err_upd;
    logic [7:0]        scale_gap;
    logic              zero_codes;

    always_comb
    begin
        max_upd = (data_byte > max_reg) ? data_byte : max_reg;
        err_upd = (data_byte == mxrq_pkg::NAN_SCALE) ? mxrq_pkg::STATUS_NAN : err_reg;
        if (cmd.last_scale && (err_upd == mxrq_pkg::STATUS_OK)
            && (max_upd < mxrq_pkg::SCALE_BIAS)) begin
            err_upd = mxrq_pkg::STATUS_SMALL;
        end

        max_next = max_reg;
        err_next = err_reg;
        if (cmd.take) begin
            if (cmd.scale_phase) begin
                max_next = max_upd;
                err_next = err_upd;
            end
            else if (cmd.last_pair) begin
                max_next = '0;
                err_next = mxrq_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_reg <= '0;
            err_reg <= mxrq_pkg::STATUS_OK;
        end
        else begin
            max_reg <= max_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && cmd.scale_phase) begin
            scale_mem[cmd.scale_addr] <= data_byte;
        end
        if (cmd.take && !cmd.scale_phase) begin
            scale_q_reg <= scale_mem[cmd.row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take) begin
            a_byte_reg <= data_byte;
            a_hdr_reg  <= cmd.scale_phase;
            a_max_reg  <= cmd.scale_phase ? max_upd : max_reg;
            a_err_reg  <= cmd.scale_phase ? err_upd : err_reg;
            a_row_reg  <= cmd.row;
            a_pair_reg <= cmd.pair;
            a_last_reg <= cmd.last_pair;
        end
    end

    // The row scale never exceeds the block maximum, so the distance is unsigned.
    assign scale_gap  = a_max_reg - scale_q_reg;
    assign zero_codes = a_hdr_reg || (a_err_reg != mxrq_pkg::STATUS_OK);

    always_ff @(posedge clk)
    begin
        if (cmd.advance) begin
            is_header    <= a_hdr_reg;
            shared_scale <= (a_hdr_reg && (a_err_reg == mxrq_pkg::STATUS_OK))
                            ? (a_max_reg - mxrq_pkg::SCALE_BIAS) : 8'd0;
            status       <= a_err_reg;
            weight_even  <= zero_codes ? 8'd0
                            : mxrq_pkg::fp4_to_e4m3(a_byte_reg[3:0], scale_gap);
            weight_odd   <= zero_codes ? 8'd0
                            : mxrq_pkg::fp4_to_e4m3(a_byte_reg[7:4], scale_gap);
            row_index    <= a_hdr_reg ? 5'd0 : 5'(a_row_reg);
            pair_index   <= a_hdr_reg ? 4'd0 : a_pair_reg;
            last         <= a_hdr_reg ? 1'b0 : a_last_reg;
        end
    end

    `MXRQ_NEXT(a_nan_scale_flags, cmd.take && cmd.scale_phase && data_byte == mxrq_pkg::NAN_SCALE,
        err_reg == mxrq_pkg::STATUS_NAN)
    `MXRQ_NEXT(a_nan_sticky, err_reg == mxrq_pkg::STATUS_NAN && !(cmd.take && cmd.last_pair),
        err_reg == mxrq_pkg::STATUS_NAN)
    `MXRQ_NEXT(a_block_end_clears, cmd.take && cmd.last_pair,
        max_reg == '0 && err_reg == mxrq_pkg::STATUS_OK)

endmodule
